// File: rtl/core/bfi_pkg.sv
// Package for the Brainfuck interpreter core: item structs, opcodes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package bfi_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_EXEC    = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_NOP     = 2'd3
  } mode_t;

  localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]
  localparam logic [7:0] CH_INC   = 8'h2B;  // +
  localparam logic [7:0] CH_DEC   = 8'h2D;  // -
  localparam logic [7:0] CH_RIGHT = 8'h3E;  // >
  localparam logic [7:0] CH_LEFT  = 8'h3C;  // <
  localparam logic [7:0] CH_OUT   = 8'h2E;  // .
  localparam logic [7:0] CH_IN    = 8'h2C;  // ,

  typedef enum logic [3:0] {
    OP_NONE, OP_INC, OP_DEC, OP_RIGHT, OP_LEFT, OP_OUT, OP_IN, OP_OPEN, OP_CLOSE
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_DECODE, ST_SF_RD, ST_SF_CHK,
    ST_SB_RD, ST_SB_CHK, ST_CLEAR, ST_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] prog_address;
    logic [7:0]  prog_byte;
    logic [7:0]  input_byte;
    logic        input_eof;
  } in_item_t;

  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        took_input;
    logic        halted;
    logic [12:0] next_pc;
  } out_item_t;

  typedef struct packed {
    logic latch_in;
    logic load_wr;
    logic clr_start;
    logic clr_step;
    logic exec;
    logic sf_start;
    logic sf_fail;
    logic sf_chk;
    logic sb_start;
    logic sb_chk;
    logic scan_addr;
    logic result;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  halted;
    op_t   op;
    logic  cell_zero;
    logic  clr_last;
    logic  sf_end;
    logic  sf_hit;
    logic  sb_hit;
    logic  sb_end;
    logic  out_free;
  } stat_t;

  function automatic op_t decode_op(input logic [7:0] ch);
    op_t op;
    case (ch)
      CH_INC:   op = OP_INC;
      CH_DEC:   op = OP_DEC;
      CH_RIGHT: op = OP_RIGHT;
      CH_LEFT:  op = OP_LEFT;
      CH_OUT:   op = OP_OUT;
      CH_IN:    op = OP_IN;
      CH_OPEN:  op = OP_OPEN;
      CH_CLOSE: op = OP_CLOSE;
      default:  op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

// File: rtl/core/bfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/bfi_ctrl.sv
// Controller state machine: sequences load, execute, scans, clearing and result.
// Depends on bfi_pkg.
module bfi_ctrl import bfi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);
  state_t state_r, state_nxt;
  logic   reply_r, reply_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      reply_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      reply_r <= reply_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    reply_nxt = reply_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat.mode)
          MODE_LOAD: begin
            cmd.load_wr = 1'b1;
            state_nxt   = ST_RESULT;
          end
          MODE_EXEC:    state_nxt = stat.halted ? ST_RESULT : ST_DECODE;
          MODE_RESTART: begin
            cmd.clr_start = 1'b1;
            reply_nxt     = 1'b1;
            state_nxt     = ST_CLEAR;
          end
          default:      state_nxt = ST_RESULT;
        endcase
      end
      ST_DECODE: begin
        if (stat.op == OP_OPEN && stat.cell_zero) begin
          cmd.sf_start = 1'b1;
          state_nxt    = ST_SF_RD;
        end else if (stat.op == OP_CLOSE) begin
          cmd.sb_start = 1'b1;
          state_nxt    = ST_SB_RD;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = ST_RESULT;
        end
      end
      ST_SF_RD: begin
        cmd.scan_addr = 1'b1;
        if (stat.sf_end) begin
          cmd.sf_fail = 1'b1;
          state_nxt   = ST_RESULT;
        end else begin
          state_nxt = ST_SF_CHK;
        end
      end
      ST_SF_CHK: begin
        cmd.sf_chk = 1'b1;
        state_nxt  = stat.sf_hit ? ST_RESULT : ST_SF_RD;
      end
      ST_SB_RD: begin
        cmd.scan_addr = 1'b1;
        state_nxt     = ST_SB_CHK;
      end
      ST_SB_CHK: begin
        cmd.sb_chk = 1'b1;
        state_nxt  = (stat.sb_hit || stat.sb_end) ? ST_RESULT : ST_SB_RD;
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          reply_nxt = 1'b0;
          state_nxt = reply_r ? ST_RESULT : ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// File: rtl/core/bfi_datapath.sv
// Datapath: program store, tape, pc/pointer, scan counters, output register.
// Depends on bfi_pkg and bfi_ram.
module bfi_datapath import bfi_pkg::*; #(
  parameter int PROGRAM_DEPTH = 4096,
  parameter int CELL_COUNT    = 65536,
  parameter int CELL_WIDTH    = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      cfg_valid,
  input  logic [12:0] cfg_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  localparam int PAW  = $clog2(PROGRAM_DEPTH);
  localparam int PCW  = $clog2(PROGRAM_DEPTH + 1);
  localparam int DPW  = $clog2(CELL_COUNT);

  in_item_t              in_r;
  logic [12:0]           plen_r;
  logic [PCW-1:0]        pc_r, k_r, depth_r;
  logic [DPW-1:0]        dp_r, clr_r;
  logic                  res_outv_r, res_took_r;
  logic [7:0]            res_byte_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [PCW-1:0]        len;
  logic [7:0]            prog_q;
  logic [CELL_WIDTH-1:0] cell_q;
  logic                  prog_we;
  logic                  tape_we;
  logic [DPW-1:0]        tape_waddr;
  logic [CELL_WIDTH-1:0] tape_wdata;
  op_t                   op;

  assign len = (32'(plen_r) > 32'(PROGRAM_DEPTH)) ? PCW'(PROGRAM_DEPTH) : PCW'(plen_r);
  assign op  = decode_op(prog_q);

  assign prog_we = cmd.load_wr && (32'(in_r.prog_address) < 32'(PROGRAM_DEPTH));

  bfi_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (PAW'(in_r.prog_address)),
    .wdata (in_r.prog_byte),
    .raddr (cmd.scan_addr ? PAW'(k_r) : PAW'(pc_r)),
    .rdata (prog_q)
  );

  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = dp_r;
    tape_wdata = cell_q;
    if (cmd.clr_step) begin
      tape_we    = 1'b1;
      tape_waddr = clr_r;
      tape_wdata = '0;
    end else if (cmd.exec) begin
      case (op)
        OP_INC: begin
          tape_we    = 1'b1;
          tape_wdata = cell_q + 1'b1;
        end
        OP_DEC: begin
          tape_we    = 1'b1;
          tape_wdata = cell_q - 1'b1;
        end
        OP_IN: begin
          tape_we    = 1'b1;
          tape_wdata = in_r.input_eof ? '1 : CELL_WIDTH'(in_r.input_byte);
        end
        default: ;
      endcase
    end
  end

  bfi_ram #(.WIDTH(CELL_WIDTH), .DEPTH(CELL_COUNT)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .raddr (dp_r),
    .rdata (cell_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r      <= '0;
      pc_r        <= '0;
      dp_r        <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) plen_r <= cfg_data;
      if (cmd.clr_start) begin
        pc_r  <= '0;
        dp_r  <= '0;
        clr_r <= '0;
      end
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.exec) begin
        pc_r <= pc_r + 1'b1;
        case (op)
          OP_RIGHT: dp_r <= (dp_r == DPW'(CELL_COUNT - 1)) ? '0 : dp_r + 1'b1;
          OP_LEFT:  dp_r <= (dp_r == '0) ? DPW'(CELL_COUNT - 1) : dp_r - 1'b1;
          default: ;
        endcase
      end
      if (cmd.sf_fail) pc_r <= len;
      if (cmd.sf_chk && stat.sf_hit) pc_r <= k_r + 1'b1;
      if (cmd.sb_chk) begin
        if (stat.sb_hit) pc_r <= k_r;
        else if (stat.sb_end) pc_r <= '0;
      end
      if (cmd.result) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r       <= in_item;
      res_outv_r <= 1'b0;
      res_took_r <= 1'b0;
      res_byte_r <= '0;
    end
    if (cmd.exec) begin
      if (op == OP_OUT) begin
        res_outv_r <= 1'b1;
        res_byte_r <= cell_q[7:0];
      end
      if (op == OP_IN && !in_r.input_eof) res_took_r <= 1'b1;
    end
    if (cmd.sf_start || cmd.sb_start) begin
      k_r     <= pc_r;
      depth_r <= '0;
    end
    if (cmd.sf_chk) begin
      k_r <= k_r + 1'b1;
      if (op == OP_OPEN) depth_r <= depth_r + 1'b1;
      else if (op == OP_CLOSE) depth_r <= depth_r - 1'b1;
    end
    if (cmd.sb_chk) begin
      k_r <= k_r - 1'b1;
      if (op == OP_CLOSE) depth_r <= depth_r + 1'b1;
      else if (op == OP_OPEN) depth_r <= depth_r - 1'b1;
    end
    if (cmd.result) begin
      out_r.out_valid  <= res_outv_r;
      out_r.out_byte   <= res_byte_r;
      out_r.took_input <= res_took_r;
      out_r.halted     <= (pc_r >= len);
      out_r.next_pc    <= 13'(pc_r);
    end
  end

  assign stat.mode      = mode_t'(in_r.mode);
  assign stat.halted    = (pc_r >= len);
  assign stat.op        = op;
  assign stat.cell_zero = (cell_q == '0);
  assign stat.clr_last  = (clr_r == DPW'(CELL_COUNT - 1));
  assign stat.sf_end    = (k_r >= len);
  assign stat.sf_hit    = (op == OP_CLOSE) && (depth_r == PCW'(1));
  assign stat.sb_hit    = (op == OP_OPEN) && (depth_r == PCW'(1));
  assign stat.sb_end    = (k_r == '0);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;
endmodule

// File: rtl/core/bf_interpreter_core_top.sv
// Brainfuck interpreter core, top level. A bracket scan walks the program one byte
// at a time, through a read state and then a check state for each byte (one program
// store read port, registered). Restart clears the whole tape, as reset does.
// Reset (rst_n, synchronous, low) clears control and then runs a tape clearing
// pass over all CELL_COUNT cells, one cell per cycle; no item is taken during it.
// Depends on bfi_pkg, bfi_ctrl, bfi_datapath, bfi_ram.
module bf_interpreter_core_top import bfi_pkg::*; #(
  parameter int PROGRAM_DEPTH = 4096,
  parameter int CELL_COUNT    = 65536,
  parameter int CELL_WIDTH    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  // program_length register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);
  cmd_t  cmd;
  stat_t stat;

  // Register writes must arrive only while idle; the block does not enforce this. They are always taken.
  assign cfg_ready = 1'b1;

  // Controller: owns the handshake on the input side and all sequencing.
  bfi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: memories, counters and the output register that decouples
  // the result side, so the next item runs while a result waits, up to its own result.
  bfi_datapath #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .CELL_COUNT    (CELL_COUNT),
    .CELL_WIDTH    (CELL_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );
endmodule

// File: rtl/core/bfi_checker.sv
// Port-level checks for the interpreter core, bound to the top level.
// Depends on bfi_pkg.
module bfi_checker import bfi_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input in_item_t    in_item,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_item,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [12:0] cfg_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous one in flight");

  a_one_io: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.out_valid && out_item.took_input))
    else $error("output and input in one step");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.out_valid |-> out_item.out_byte == 8'd0)
    else $error("out_byte set without output");
endmodule

bind bf_interpreter_core_top bfi_checker u_chk (.*);

// File: bench/tb_bf_interpreter_core_top.sv
// Self-checking testbench for bf_interpreter_core_top: loads programs, runs them step by step
// and checks every result item against an in-bench model of the machine.
// Depends on bfi_pkg and the RTL of bf_interpreter_core_top.
module tb_bf_interpreter_core_top;
  import bfi_pkg::*;

  localparam int PROG_DEPTH = 4096;
  localparam int CELLS      = 65536;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_data;

  bf_interpreter_core_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Machine state as the bench sees it; advanced when an item is accepted.
  logic [7:0]  prog_mem [PROG_DEPTH];
  logic [7:0]  tape [CELLS];
  logic [12:0] mdl_pc;
  logic [15:0] mdl_dp;
  logic [12:0] mdl_len;       // program_length register copy

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        fail_count;
  int        exec_count;
  int        send_idle_pct;
  int        recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous fixed limit: reset clear, a handful of restarts and long scans fit well inside.
  initial begin
    #50000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void clear_tape();
    foreach (tape[i]) tape[i] = 8'h00;
    mdl_pc = '0;
    mdl_dp = '0;
  endfunction

  // Run one item through the machine copy and return the result it must produce.
  function automatic out_item_t bf_step(in_item_t it);
    out_item_t r;
    int len, k, depth;
    logic [7:0] op;
    r = '0;
    len = (mdl_len > PROG_DEPTH) ? PROG_DEPTH : int'(mdl_len);
    case (it.mode)
      MODE_LOAD: prog_mem[it.prog_address] = it.prog_byte;
      MODE_RESTART: clear_tape();
      MODE_EXEC: begin
        if (int'(mdl_pc) < len) begin
          op = prog_mem[mdl_pc];
          case (op)
            CH_INC:   begin tape[mdl_dp] = tape[mdl_dp] + 8'd1; mdl_pc = mdl_pc + 13'd1; end
            CH_DEC:   begin tape[mdl_dp] = tape[mdl_dp] - 8'd1; mdl_pc = mdl_pc + 13'd1; end
            CH_RIGHT: begin mdl_dp = mdl_dp + 16'd1; mdl_pc = mdl_pc + 13'd1; end
            CH_LEFT:  begin mdl_dp = mdl_dp - 16'd1; mdl_pc = mdl_pc + 13'd1; end
            CH_OUT: begin
              r.out_valid = 1'b1;
              r.out_byte  = tape[mdl_dp];
              mdl_pc = mdl_pc + 13'd1;
            end
            CH_IN: begin
              if (it.input_eof) begin
                tape[mdl_dp] = 8'hFF;
              end else begin
                tape[mdl_dp] = it.input_byte;
                r.took_input = 1'b1;
              end
              mdl_pc = mdl_pc + 13'd1;
            end
            CH_OPEN: begin
              if (tape[mdl_dp] == 8'h00) begin
                // forward scan to the matching close; runs off the end if unmatched
                depth = 0;
                for (k = int'(mdl_pc); k < len; k++) begin
                  if (prog_mem[k] == CH_OPEN) depth++;
                  else if (prog_mem[k] == CH_CLOSE) begin
                    depth--;
                    if (depth == 0) break;
                  end
                end
                mdl_pc = (k < len) ? 13'(k + 1) : 13'(len);
              end else begin
                mdl_pc = mdl_pc + 13'd1;
              end
            end
            CH_CLOSE: begin
              // backward scan lands on the matching open; unmatched goes to 0
              depth = 0;
              k = int'(mdl_pc) + 1;
              mdl_pc = '0;
              while (k > 0) begin
                k--;
                if (prog_mem[k] == CH_CLOSE) depth++;
                else if (prog_mem[k] == CH_OPEN) begin
                  if (depth == 1) begin
                    mdl_pc = 13'(k);
                    break;
                  end
                  depth--;
                end
              end
            end
            default: mdl_pc = mdl_pc + 13'd1;
          endcase
        end
      end
      default: ;
    endcase
    r.halted  = (int'(mdl_pc) >= len);
    r.next_pc = mdl_pc;
    return r;
  endfunction

  // Driver: predicts on acceptance, then presents the next item or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      clear_tape();
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(bf_step(in_item));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure and field-by-field compare.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item.out_valid !== exp_r.out_valid) begin
            $error("out_valid exp %0d got %0d", exp_r.out_valid, out_item.out_valid);
            fail_count++;
          end
          if (out_item.out_byte !== exp_r.out_byte) begin
            $error("out_byte exp %0d got %0d", exp_r.out_byte, out_item.out_byte);
            fail_count++;
          end
          if (out_item.took_input !== exp_r.took_input) begin
            $error("took_input exp %0d got %0d", exp_r.took_input, out_item.took_input);
            fail_count++;
          end
          if (out_item.halted !== exp_r.halted) begin
            $error("halted exp %0d got %0d", exp_r.halted, out_item.halted);
            fail_count++;
          end
          if (out_item.next_pc !== exp_r.next_pc) begin
            $error("next_pc exp %0d got %0d", exp_r.next_pc, out_item.next_pc);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_item(logic [1:0] mode, int addr, logic [7:0] data);
    in_item_t it;
    it.mode         = mode;
    it.prog_address = addr[11:0];
    it.prog_byte    = data;
    it.input_byte   = $urandom_range(255);
    it.input_eof    = ($urandom_range(4) == 0);
    pending_items.push_back(it);
    if (mode == MODE_EXEC) exec_count++;
  endtask

  task automatic load_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(MODE_LOAD, i, s[i]);
  endtask

  task automatic run_steps(int n);
    repeat (n) push_item(MODE_EXEC, 0, 8'h00);
  endtask

  // Idle point: nothing queued, nothing in flight.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_length(logic [12:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    mdl_len = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] any_cmd();
    case ($urandom_range(9))
      0: return CH_INC;
      1: return CH_DEC;
      2: return CH_RIGHT;
      3: return CH_LEFT;
      4: return CH_OUT;
      5: return CH_IN;
      6: return CH_OPEN;
      7: return CH_CLOSE;
      8: return CH_INC;
      default: return $urandom_range(255);
    endcase
  endfunction

  // Balanced body with random content, closed by an unmatched ']' that loops back to 0.
  task automatic load_program(int len);
    int open_cnt, left;
    logic [7:0] c;
    open_cnt = 0;
    for (int i = 0; i < len - 1; i++) begin
      left = len - 1 - i;
      case ($urandom_range(19))
        0, 1:  c = (left > open_cnt + 1) ? CH_OPEN : CH_INC;
        2, 3:  c = (open_cnt > 0) ? CH_CLOSE : CH_DEC;
        4:     c = $urandom_range(255);
        5, 6:  c = CH_OUT;
        7:     c = CH_IN;
        8, 9:  c = CH_RIGHT;
        10:    c = CH_LEFT;
        11, 12: c = CH_DEC;
        default: c = CH_INC;
      endcase
      if (left == open_cnt) c = CH_CLOSE;
      if (c == CH_OPEN) open_cnt++;
      if (c == CH_CLOSE) open_cnt--;
      push_item(MODE_LOAD, i, c);
    end
    push_item(MODE_LOAD, len - 1, CH_CLOSE);
  endtask

  initial begin
    int len, restarts;
    logic [7:0] c;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    fail_count = 0;
    exec_count = 0;
    restarts   = 0;
    send_idle_pct  = 27;
    recv_stall_pct = 88;
    mdl_len = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Length 0: every step reports halted; no-op mode too.
    write_length(13'd0);
    run_steps(2);
    push_item(MODE_NOP, 0, 8'h00);
    wait_idle();

    // Directed: skip over a loop on zero, all simple ops, reads with end of input
    // set at random per item, then an unmatched close back to 0.
    write_length(13'd13);
    load_text("[+]+.-<>,.,.]");
    run_steps(16);
    push_item(MODE_NOP, 0, 8'h00);
    wait_idle();
    // Unmatched open on a zero cell halts; stepping while halted changes nothing.
    push_item(MODE_RESTART, 0, 8'h00);
    restarts++;
    load_text("<.[+");
    wait_idle();
    write_length(13'd4);
    run_steps(5);
    wait_idle();

    // Bracket-free bytes behind the short program, so long lengths only walk
    // bytes that were written.
    for (int a = 4; a < 48; a++) begin
      do c = any_cmd();
      while (c == CH_OPEN || c == CH_CLOSE);
      push_item(MODE_LOAD, a, c);
    end
    wait_idle();

    // Extreme lengths over the bracket-free tail.
    write_length(13'd4096);
    run_steps(20);
    wait_idle();
    write_length(13'h1FFF);
    run_steps(20);
    wait_idle();
    write_length(13'd1);
    run_steps(3);
    wait_idle();

    while (exec_count < 1450) begin
      if (exec_count >= 960) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if (exec_count >= 480) begin
        send_idle_pct  = 88;
        recv_stall_pct = 27;
      end
      len = $urandom_range(8, 64);
      if (int'(mdl_pc) + 2 > 64) begin
        push_item(MODE_RESTART, 0, 8'h00);
        restarts++;
      end else if (len < int'(mdl_pc) + 2) begin
        len = int'(mdl_pc) + 2;
      end
      if ($urandom_range(9) == 0) begin
        // broken program: random bytes, unmatched brackets likely
        for (int i = 0; i < len; i++) push_item(MODE_LOAD, i, any_cmd());
      end else begin
        load_program(len);
      end
      wait_idle();
      write_length(len[12:0]);
      for (int i = 0; i < 3 * len; i++) begin
        case ($urandom_range(29))
          0: push_item(MODE_NOP, 0, 8'h00);
          1: push_item(MODE_LOAD, $urandom_range(PROG_DEPTH - 1, len), any_cmd());
          default: push_item(MODE_EXEC, 0, 8'h00);
        endcase
      end
      // a rare restart mid-run, bounded since each one clears the whole tape
      if (restarts < 4 && $urandom_range(15) == 0) begin
        push_item(MODE_RESTART, 0, 8'h00);
        restarts++;
        run_steps(10);
      end
      wait_idle();
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/bfi_pkg.sv
rtl/core/bfi_ram.sv
rtl/core/bfi_ctrl.sv
rtl/core/bfi_datapath.sv
rtl/core/bf_interpreter_core_top.sv
rtl/core/bfi_checker.sv
bench/tb_bf_interpreter_core_top.sv
